[rtl/core/scrd_pkg.sv]
`default_nettype none

package scrd_pkg;

  localparam int NumRegs = 22;
  localparam int IdxW    = $clog2(NumRegs);
  localparam int ByteW   = 8;
  localparam int OffW    = 2;
  localparam int AddrW   = 10;
  localparam int IrqW    = 4;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [OffW-1:0]  off_t;
  typedef logic [AddrW-1:0] addr_t;
  typedef logic [IrqW-1:0]  irq_t;

  // access kinds and port offsets
  localparam logic ActWrite = 1'b1;
  localparam off_t OffKey   = 2'd0;
  localparam off_t OffIndex = 2'd1;
  localparam off_t OffData  = 2'd2;

  // register indexes
  localparam int RegFdc     = 0;
  localparam int RegPortSel = 1;
  localparam int RegSerSwap = 3;
  localparam int RegPortDis = 4;
  localparam int RegFdcAlt  = 6;
  localparam int RegId      = 7;
  localparam int RegMode    = 9;
  localparam int RegKeySel  = 12;

  // bit positions
  localparam int KeySelBit  = 5;
  localparam int FdcPriBit  = 4;
  localparam int FdcDisBit  = 5;
  localparam int FdcAltBit  = 3;
  localparam int WpBit      = 6;

  localparam byte_t KeyBase    = 8'h88;
  localparam byte_t FdcAltMask = 8'hF3;
  localparam byte_t IdMask     = 8'h0F;
  localparam byte_t ReadNone   = 8'hFF;
  localparam byte_t ModeReset  = 8'h09;

  localparam addr_t Com1Base   = 10'h3F8;
  localparam addr_t Com2Base   = 10'h2F8;
  localparam addr_t Com3Base   = 10'h3E8;
  localparam addr_t Com4Base   = 10'h2E8;
  localparam addr_t LptMono    = 10'h3BC;
  localparam addr_t Lpt2Base   = 10'h278;
  localparam addr_t Lpt1Base   = 10'h378;
  localparam addr_t FdcPriBase = 10'h3F0;
  localparam addr_t FdcSecBase = 10'h370;

  localparam irq_t Irq3 = 4'd3;
  localparam irq_t Irq4 = 4'd4;
  localparam irq_t Irq5 = 4'd5;
  localparam irq_t Irq7 = 4'd7;

  typedef struct packed {
    addr_t base;
    irq_t  irq;
    logic  on;
  } port_res_t;

  typedef struct packed {
    port_res_t ser_a;
    port_res_t ser_b;
    port_res_t prn;
  } res_t;

  function automatic byte_t reg_reset(input int unsigned i);
    byte_t v;
    case (i)
      0:       v = 8'h50;
      1:       v = 8'h2C;
      3:       v = 8'h30;
      7:       v = 8'hF5;
      9:       v = ModeReset;
      10:      v = 8'h1F;
      12:      v = 8'h2C;
      13:      v = 8'hA3;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/core/scrd_if.sv]
`default_nettype none

interface scrd_in_if;
  import scrd_pkg::*;

  logic  valid;
  logic  ready;
  logic  action;
  off_t  port_offset;
  byte_t write_data;

  modport source(output valid, output action, output port_offset, output write_data,
                 input ready);
  modport sink(input valid, input action, input port_offset, input write_data,
               output ready);
endinterface

interface scrd_out_if;
  import scrd_pkg::*;

  logic  valid;
  logic  ready;
  byte_t read_data;
  addr_t serial_a_base;
  irq_t  serial_a_irq;
  logic  serial_a_on;
  addr_t serial_b_base;
  irq_t  serial_b_irq;
  logic  serial_b_on;
  addr_t printer_base;
  irq_t  printer_irq;
  logic  printer_on;
  addr_t floppy_base;
  logic  floppy_on;

  modport source(output valid, output read_data,
                 output serial_a_base, output serial_a_irq, output serial_a_on,
                 output serial_b_base, output serial_b_irq, output serial_b_on,
                 output printer_base, output printer_irq, output printer_on,
                 output floppy_base, output floppy_on, input ready);
  modport sink(input valid, input read_data,
               input serial_a_base, input serial_a_irq, input serial_a_on,
               input serial_b_base, input serial_b_irq, input serial_b_on,
               input printer_base, input printer_irq, input printer_on,
               input floppy_base, input floppy_on, output ready);
endinterface

`default_nettype wire

[rtl/core/scrd_res_decode.sv]
`default_nettype none

module scrd_res_decode (
  input  scrd_pkg::byte_t port_sel_i,
  input  scrd_pkg::byte_t ser_swap_i,
  input  scrd_pkg::byte_t port_dis_i,
  output scrd_pkg::res_t  res_o
);
  import scrd_pkg::*;

  logic [1:0] sel_a;
  logic [1:0] sel_b;
  logic [1:0] sel_p;

  assign sel_a = {port_sel_i[2], port_sel_i[0]};
  assign sel_b = {port_sel_i[3], port_sel_i[1]};
  assign sel_p = {port_sel_i[5], port_sel_i[4]};

  always_comb begin
    res_o.ser_a = '{base: Com1Base, irq: Irq4, on: 1'b1};
    if (ser_swap_i[3]) begin
      res_o.ser_a.base = Com2Base;
      res_o.ser_a.irq  = Irq3;
    end else begin
      unique case (sel_a)
        2'd0: begin
          res_o.ser_a.base = Com4Base;
          res_o.ser_a.irq  = Irq3;
        end
        2'd1: begin
          res_o.ser_a.base = Com3Base;
        end
        2'd2: begin
          res_o.ser_a.base = Com1Base;
        end
        default: begin
          res_o.ser_a.on = 1'b0;
        end
      endcase
    end
    if (port_dis_i[5]) begin
      res_o.ser_a.on = 1'b0;
    end

    res_o.ser_b = '{base: Com1Base, irq: Irq4, on: 1'b1};
    if (!ser_swap_i[2]) begin
      unique case (sel_b)
        2'd0: begin
          res_o.ser_b.base = Com3Base;
        end
        2'd1: begin
          res_o.ser_b.base = Com4Base;
          res_o.ser_b.irq  = Irq3;
        end
        2'd2: begin
          res_o.ser_b.base = Com2Base;
          res_o.ser_b.irq  = Irq3;
        end
        default: begin
          res_o.ser_b.on = 1'b0;
        end
      endcase
    end
    if (port_dis_i[4]) begin
      res_o.ser_b.on = 1'b0;
    end

    res_o.prn = '{base: Lpt1Base, irq: Irq7, on: 1'b1};
    unique case (sel_p)
      2'd0: begin
        res_o.prn.base = LptMono;
      end
      2'd1: begin
        res_o.prn.base = Lpt2Base;
        res_o.prn.irq  = Irq5;
      end
      2'd2: begin
        res_o.prn.base = Lpt1Base;
      end
      default: begin
        res_o.prn.on = 1'b0;
      end
    endcase
    if (port_dis_i[7]) begin
      res_o.prn.on = 1'b0;
    end
  end

endmodule

`default_nettype wire

[rtl/core/superio_config_register_decoder.sv]
`default_nettype none

// A beat's result is registered on the clock edge that accepts the beat.
// Throughput: one beat per cycle while the output side is ready; the register
// file and the decode sit between the input handshake and a single output register.
// Reset: asynchronous, active low; registers load their power-on table,
// the port is locked, unprotected, index 0, floppy primary and enabled.

module superio_config_register_decoder (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             cfg_we_i,
  input  scrd_pkg::byte_t cfg_wdata_i,
  scrd_in_if.sink         in_i,
  scrd_out_if.source      out_o
);
  import scrd_pkg::*;

  byte_t regs_q [NumRegs];
  byte_t regs_d [NumRegs];
  idx_t  idx_q, idx_d;
  logic  unlocked_q, unlocked_d;
  logic  wp_q, wp_d;
  logic  fdc_pri_q, fdc_pri_d;
  logic  fdc_en_q, fdc_en_d;

  logic  out_valid_q, out_valid_d;
  byte_t rdata_q, rdata_d;
  res_t  res_q, res_d;
  logic  fdc_pri_out_q;
  logic  fdc_en_out_q;

  logic  accept;
  logic  is_wr;
  byte_t cur;
  byte_t wval;
  byte_t diff;
  byte_t key;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign is_wr      = in_i.action == ActWrite;
  assign cur        = regs_q[idx_q];
  assign wval       = (idx_q == idx_t'(RegFdcAlt)) ? (in_i.write_data & FdcAltMask)
                                                   : in_i.write_data;
  assign diff       = wval ^ cur;
  assign key        = KeyBase | {{(ByteW-1){1'b0}}, regs_q[RegKeySel][KeySelBit]};

  always_comb begin
    regs_d     = regs_q;
    idx_d      = idx_q;
    unlocked_d = unlocked_q;
    wp_d       = wp_q;
    fdc_pri_d  = fdc_pri_q;
    fdc_en_d   = fdc_en_q;
    if (accept && is_wr) begin
      unique case (in_i.port_offset)
        OffKey: begin
          unlocked_d = in_i.write_data == key;
        end
        OffIndex: begin
          if (in_i.write_data <= byte_t'(NumRegs - 1)) begin
            idx_d = in_i.write_data[IdxW-1:0];
          end
        end
        OffData: begin
          if (unlocked_q && !wp_q) begin
            regs_d[idx_q] = wval;
            if (idx_q == idx_t'(RegFdc) && (diff[FdcPriBit] || diff[FdcDisBit])) begin
              fdc_en_d = !wval[FdcDisBit];
              if (!wval[FdcDisBit]) begin
                fdc_pri_d = wval[FdcPriBit];
              end
            end else if (idx_q == idx_t'(RegFdcAlt) && diff[FdcAltBit]) begin
              fdc_en_d = !wval[FdcAltBit];
              if (!wval[FdcAltBit]) begin
                fdc_pri_d = 1'b1;
              end
            end else if (idx_q == idx_t'(RegMode) && diff[WpBit]) begin
              wp_d = wval[WpBit];
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (cfg_we_i) begin
      regs_d[RegMode] = cfg_wdata_i;
    end
  end

  always_comb begin
    rdata_d = ReadNone;
    if (!is_wr && unlocked_q) begin
      unique case (in_i.port_offset)
        OffIndex: begin
          rdata_d = {{(ByteW-IdxW){1'b0}}, idx_q};
        end
        OffData: begin
          if (idx_q == idx_t'(RegId)) begin
            rdata_d = cur & IdMask;
          end else if (!wp_q) begin
            rdata_d = cur;
          end
        end
        default: begin
          rdata_d = ReadNone;
        end
      endcase
    end
  end

  scrd_res_decode u_res_decode (
    .port_sel_i (regs_d[RegPortSel]),
    .ser_swap_i (regs_d[RegSerSwap]),
    .port_dis_i (regs_d[RegPortDis]),
    .res_o      (res_d)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        regs_q[i] <= reg_reset(i);
      end
      idx_q       <= '0;
      unlocked_q  <= 1'b0;
      wp_q        <= 1'b0;
      fdc_pri_q   <= 1'b1;
      fdc_en_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      regs_q      <= regs_d;
      idx_q       <= idx_d;
      unlocked_q  <= unlocked_d;
      wp_q        <= wp_d;
      fdc_pri_q   <= fdc_pri_d;
      fdc_en_q    <= fdc_en_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rdata_q       <= rdata_d;
      res_q         <= res_d;
      fdc_pri_out_q <= fdc_pri_d;
      fdc_en_out_q  <= fdc_en_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.read_data     = rdata_q;
  assign out_o.serial_a_base = res_q.ser_a.base;
  assign out_o.serial_a_irq  = res_q.ser_a.irq;
  assign out_o.serial_a_on   = res_q.ser_a.on;
  assign out_o.serial_b_base = res_q.ser_b.base;
  assign out_o.serial_b_irq  = res_q.ser_b.irq;
  assign out_o.serial_b_on   = res_q.ser_b.on;
  assign out_o.printer_base  = res_q.prn.base;
  assign out_o.printer_irq   = res_q.prn.irq;
  assign out_o.printer_on    = res_q.prn.on;
  assign out_o.floppy_base   = fdc_pri_out_q ? FdcPriBase : FdcSecBase;
  assign out_o.floppy_on     = fdc_en_out_q;

endmodule

`default_nettype wire
